// ===== rtl/aabb_pair_collision_contact_macros.svh =====
// Assertion macros for the checker file of the box collision block.
`ifndef AABB_PAIR_COLLISION_CONTACT_MACROS_SVH
`define AABB_PAIR_COLLISION_CONTACT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define APC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/apc_pkg.sv =====
// Types and constants shared by the box collision block and its checker.
package apc_pkg;

  // Field widths of the box description and of the results.
  localparam int CENTER_W = 31;
  localparam int SIZE_W   = 30;
  localparam int HALF_W   = SIZE_W - 1;
  localparam int EDGE_W   = CENTER_W + 1;
  localparam int GAP_W    = EDGE_W + 1;
  localparam int COORD_W  = 32;
  localparam int NORMAL_W = 2;

  // Unit normal components.
  localparam logic signed [NORMAL_W-1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [NORMAL_W-1:0] NORM_POS  = 2'sb01;
  localparam logic signed [NORMAL_W-1:0] NORM_NEG  = 2'sb11;

  // Faces in tie-break order.
  typedef enum logic [1:0] {
    FACE_POS_X,
    FACE_NEG_X,
    FACE_POS_Y,
    FACE_NEG_Y
  } face_t;

  // One box as it arrives: centre and full size.
  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [SIZE_W-1:0]          w;
    logic [SIZE_W-1:0]          h;
  } box_t;

endpackage

// ===== rtl/aabb_pair_collision_contact.sv =====
// Box pair collision test with contact point, face normal and penetration depth.
//
// The block takes one pair of axis-aligned boxes per clock and returns one
// result per pair, so it sustains one transfer per cycle on both channels
// while the output is not stalled. A pair is captured in the input register,
// all edge, overlap, clamp and minimum-gap logic runs in a single pass to the
// result register, and the result is offered once the result register has
// loaded it. Both registers move independently, so a new pair is taken while
// a finished result still waits on a stalled output; the input stalls only
// when both registers are full and the output is stalled.
module aabb_pair_collision_contact (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [apc_pkg::CENTER_W-1:0]  own_center_x,
  input  logic signed [apc_pkg::CENTER_W-1:0]  own_center_y,
  input  logic        [apc_pkg::SIZE_W-1:0]    own_width,
  input  logic        [apc_pkg::SIZE_W-1:0]    own_height,
  input  logic signed [apc_pkg::CENTER_W-1:0]  other_center_x,
  input  logic signed [apc_pkg::CENTER_W-1:0]  other_center_y,
  input  logic        [apc_pkg::SIZE_W-1:0]    other_width,
  input  logic        [apc_pkg::SIZE_W-1:0]    other_height,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic signed [apc_pkg::COORD_W-1:0]   contact_x,
  output logic signed [apc_pkg::COORD_W-1:0]   contact_y,
  output logic signed [apc_pkg::NORMAL_W-1:0]  normal_x,
  output logic signed [apc_pkg::NORMAL_W-1:0]  normal_y,
  output logic        [apc_pkg::COORD_W-1:0]   penetration
);
  import apc_pkg::*;

  // Absolute difference between edges a and b; the gap always fits the coordinate width.
  function automatic logic [COORD_W-1:0] abs_gap(input logic signed [EDGE_W-1:0] a,
                                                 input logic signed [EDGE_W-1:0] b);
    logic signed [GAP_W-1:0] d;
    logic signed [GAP_W-1:0] nd;
    d  = {a[EDGE_W-1], a} - {b[EDGE_W-1], b};
    nd = -d;
    return d[GAP_W-1] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  // Sign-extend a centre to edge width.
  function automatic logic signed [EDGE_W-1:0] ext_c(input logic signed [CENTER_W-1:0] c);
    return {c[CENTER_W-1], c};
  endfunction

  // Zero-extend a half extent to edge width.
  function automatic logic signed [EDGE_W-1:0] ext_h(input logic [HALF_W-1:0] h);
    return {{(EDGE_W - HALF_W){1'b0}}, h};
  endfunction

  logic pair_valid;
  box_t own_box;
  box_t other_box;

  logic pair_ready;
  logic out_ready;

  logic [HALF_W-1:0] own_hw, own_hh, oth_hw, oth_hh;
  logic signed [EDGE_W-1:0] a_left, a_right, a_bot, a_top;
  logic signed [EDGE_W-1:0] b_left, b_right, b_bot, b_top;
  logic overlap;

  logic signed [EDGE_W-1:0] dx, dy, hx, hy, nhx, nhy, clx, cly;
  logic signed [EDGE_W-1:0] cx_sum, cy_sum;

  logic [COORD_W-1:0] g_px, g_nx, g_py, g_ny;
  logic               x_neg, y_neg, pick_y;
  logic [COORD_W-1:0] x_min, y_min, best;
  face_t              face;
  logic signed [NORMAL_W-1:0] nrm_x, nrm_y;

  // Handshake: each register advances when the stage after it can take data.
  assign out_ready  = !out_valid || !out_stall;
  assign pair_ready = !pair_valid || out_ready;
  assign in_stall   = !pair_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (pair_ready) begin
      pair_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_ready && in_valid) begin
      own_box   <= '{cx: own_center_x, cy: own_center_y, w: own_width, h: own_height};
      other_box <= '{cx: other_center_x, cy: other_center_y,
                     w: other_width, h: other_height};
    end
  end

  // Half extents and box edges.
  always_comb begin
    own_hw  = own_box.w[SIZE_W-1:1];
    own_hh  = own_box.h[SIZE_W-1:1];
    oth_hw  = other_box.w[SIZE_W-1:1];
    oth_hh  = other_box.h[SIZE_W-1:1];
    a_left  = ext_c(own_box.cx) - ext_h(own_hw);
    a_right = ext_c(own_box.cx) + ext_h(own_hw);
    a_bot   = ext_c(own_box.cy) - ext_h(own_hh);
    a_top   = ext_c(own_box.cy) + ext_h(own_hh);
    b_left  = ext_c(other_box.cx) - ext_h(oth_hw);
    b_right = ext_c(other_box.cx) + ext_h(oth_hw);
    b_bot   = ext_c(other_box.cy) - ext_h(oth_hh);
    b_top   = ext_c(other_box.cy) + ext_h(oth_hh);
    overlap = (a_right > b_left) && (a_left < b_right) &&
              (a_top > b_bot) && (a_bot < b_top);
  end

  // Contact point: centre difference clamped to the own half extents.
  always_comb begin
    dx  = ext_c(other_box.cx) - ext_c(own_box.cx);
    dy  = ext_c(other_box.cy) - ext_c(own_box.cy);
    hx  = ext_h(own_hw);
    hy  = ext_h(own_hh);
    nhx = -hx;
    nhy = -hy;
    if (dx > hx) begin
      clx = hx;
    end else if (dx < nhx) begin
      clx = nhx;
    end else begin
      clx = dx;
    end
    if (dy > hy) begin
      cly = hy;
    end else if (dy < nhy) begin
      cly = nhy;
    end else begin
      cly = dy;
    end
    cx_sum = ext_c(own_box.cx) + clx;
    cy_sum = ext_c(own_box.cy) + cly;
  end

  // Face gaps and a two-level minimum; on ties the earlier face wins.
  always_comb begin
    g_px   = abs_gap(a_right, b_left);
    g_nx   = abs_gap(a_left, b_right);
    g_py   = abs_gap(a_top, b_bot);
    g_ny   = abs_gap(a_bot, b_top);
    x_neg  = g_nx < g_px;
    y_neg  = g_ny < g_py;
    x_min  = x_neg ? g_nx : g_px;
    y_min  = y_neg ? g_ny : g_py;
    pick_y = y_min < x_min;
    best   = pick_y ? y_min : x_min;
    if (pick_y) begin
      face = y_neg ? FACE_NEG_Y : FACE_POS_Y;
    end else begin
      face = x_neg ? FACE_NEG_X : FACE_POS_X;
    end
  end

  // Unit normal of the chosen face.
  always_comb begin
    unique case (face)
      FACE_POS_X: begin
        nrm_x = NORM_POS;
        nrm_y = NORM_ZERO;
      end
      FACE_NEG_X: begin
        nrm_x = NORM_NEG;
        nrm_y = NORM_ZERO;
      end
      FACE_POS_Y: begin
        nrm_x = NORM_ZERO;
        nrm_y = NORM_POS;
      end
      FACE_NEG_Y: begin
        nrm_x = NORM_ZERO;
        nrm_y = NORM_NEG;
      end
      default: begin
        nrm_x = NORM_ZERO;
        nrm_y = NORM_ZERO;
      end
    endcase
  end

  // Result register; a miss reports all-zero fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && pair_valid) begin
      hit         <= overlap;
      contact_x   <= overlap ? cx_sum[COORD_W-1:0] : '0;
      contact_y   <= overlap ? cy_sum[COORD_W-1:0] : '0;
      normal_x    <= overlap ? nrm_x : NORM_ZERO;
      normal_y    <= overlap ? nrm_y : NORM_ZERO;
      penetration <= overlap ? best : '0;
    end
  end

endmodule

// ===== rtl/apc_checker.sv =====
// Port-level checker for the box collision block, bound to its top level.
`include "aabb_pair_collision_contact_macros.svh"

module apc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 hit,
  input logic signed [apc_pkg::COORD_W-1:0]   contact_x,
  input logic signed [apc_pkg::COORD_W-1:0]   contact_y,
  input logic signed [apc_pkg::NORMAL_W-1:0]  normal_x,
  input logic signed [apc_pkg::NORMAL_W-1:0]  normal_y,
  input logic        [apc_pkg::COORD_W-1:0]   penetration
);
  import apc_pkg::*;

  // No result is shown in the cycle after a reset edge.
  `APC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // A stalled result stays offered.
  `APC_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid, "stalled result dropped")

  // A miss carries only zero fields.
  `APC_ASSERT(a_miss_zero,
    out_valid && !hit |-> contact_x == '0 && contact_y == '0 &&
    normal_x == NORM_ZERO && normal_y == NORM_ZERO && penetration == '0,
    "miss with nonzero fields")

  // A hit carries exactly one unit axis and a positive depth.
  `APC_ASSERT(a_hit_normal,
    out_valid && hit |-> ((normal_x == NORM_POS || normal_x == NORM_NEG) &&
    normal_y == NORM_ZERO) || ((normal_y == NORM_POS || normal_y == NORM_NEG) &&
    normal_x == NORM_ZERO), "hit without a unit face normal")

  `APC_ASSERT(a_hit_depth, out_valid && hit |-> penetration != '0, "hit with zero depth")

endmodule

bind aabb_pair_collision_contact apc_checker u_apc_checker (.*);

// ===== tb/aabb_pair_collision_contact_tb.sv =====
// Self-checking testbench for the box pair collision block with contact, normal and depth.
module aabb_pair_collision_contact_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apc_pkg::*;

  localparam longint MAX_CENTER = 64'sd1073741823;
  localparam longint MIN_CENTER = -64'sd1073741824;
  localparam longint MAX_SIZE   = 64'sd1073741823;
  localparam longint ONE        = 64'sd65536;
  localparam int     RANDOM_PAIRS = 1030;
  localparam int     PHASE1_AT    = 340;
  localparam int     PHASE2_AT    = 690;
  localparam int     DRAIN_AT     = 520;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     CYCLE_LIMIT   = 200000;

  // A pair of boxes as carried by one input transfer.
  typedef struct {
    box_t own;
    box_t other;
  } box_pair_t;

  // The result of one collision test.
  typedef struct {
    logic                       hit;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [NORMAL_W-1:0] nx;
    logic signed [NORMAL_W-1:0] ny;
    logic [COORD_W-1:0]         depth;
  } contact_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [CENTER_W-1:0]  own_center_x = '0;
  logic signed [CENTER_W-1:0]  own_center_y = '0;
  logic [SIZE_W-1:0]           own_width = '0;
  logic [SIZE_W-1:0]           own_height = '0;
  logic signed [CENTER_W-1:0]  other_center_x = '0;
  logic signed [CENTER_W-1:0]  other_center_y = '0;
  logic [SIZE_W-1:0]           other_width = '0;
  logic [SIZE_W-1:0]           other_height = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        hit;
  logic signed [COORD_W-1:0]   contact_x;
  logic signed [COORD_W-1:0]   contact_y;
  logic signed [NORMAL_W-1:0]  normal_x;
  logic signed [NORMAL_W-1:0]  normal_y;
  logic [COORD_W-1:0]          penetration;

  box_pair_t pending_pairs[$];
  contact_t  expected_contacts[$];
  int        accepted_pairs = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        drain_done = 1'b0;

  aabb_pair_collision_contact dut (.*);

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp a centre difference to plus or minus the half extent.
  function automatic longint clamp_half(longint d, longint h);
    if (d > h) return h;
    if (d < -h) return -h;
    return d;
  endfunction

  function automatic longint face_gap(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Work out the collision result for one pair of boxes.
  function automatic contact_t predict_contact(box_pair_t p);
    longint   ax, ay, ahw, ahh, bx, by, bhw, bhh;
    longint   a_l, a_r, a_b, a_t, b_l, b_r, b_b, b_t;
    longint   gap [4];
    face_t    face;
    contact_t res;
    ax  = p.own.cx;
    ay  = p.own.cy;
    ahw = longint'(p.own.w >> 1);
    ahh = longint'(p.own.h >> 1);
    bx  = p.other.cx;
    by  = p.other.cy;
    bhw = longint'(p.other.w >> 1);
    bhh = longint'(p.other.h >> 1);
    a_l = ax - ahw;
    a_r = ax + ahw;
    a_b = ay - ahh;
    a_t = ay + ahh;
    b_l = bx - bhw;
    b_r = bx + bhw;
    b_b = by - bhh;
    b_t = by + bhh;
    res = '{hit: 1'b0, cx: '0, cy: '0, nx: NORM_ZERO, ny: NORM_ZERO, depth: '0};
    if (!(a_r > b_l && a_l < b_r && a_t > b_b && a_b < b_t)) return res;

    res.hit = 1'b1;
    res.cx  = COORD_W'(ax + clamp_half(bx - ax, ahw));
    res.cy  = COORD_W'(ay + clamp_half(by - ay, ahh));

    // Smallest face gap; on a tie the earlier face keeps the win.
    gap[FACE_POS_X] = face_gap(a_r, b_l);
    gap[FACE_NEG_X] = face_gap(a_l, b_r);
    gap[FACE_POS_Y] = face_gap(a_t, b_b);
    gap[FACE_NEG_Y] = face_gap(a_b, b_t);
    face = FACE_POS_X;
    for (int f = 1; f < 4; f++) begin
      if (gap[f] < gap[face]) face = face_t'(f);
    end
    case (face)
      FACE_POS_X: begin res.nx = NORM_POS;  res.ny = NORM_ZERO; end
      FACE_NEG_X: begin res.nx = NORM_NEG;  res.ny = NORM_ZERO; end
      FACE_POS_Y: begin res.nx = NORM_ZERO; res.ny = NORM_POS;  end
      default:    begin res.nx = NORM_ZERO; res.ny = NORM_NEG;  end
    endcase
    res.depth = COORD_W'(gap[face]);
    return res;
  endfunction

  function automatic void queue_pair(longint ocx, longint ocy, longint ow, longint oh,
                                     longint bcx, longint bcy, longint bw, longint bh);
    box_pair_t p;
    p.own   = '{cx: CENTER_W'(ocx), cy: CENTER_W'(ocy), w: SIZE_W'(ow), h: SIZE_W'(oh)};
    p.other = '{cx: CENTER_W'(bcx), cy: CENTER_W'(bcy), w: SIZE_W'(bw), h: SIZE_W'(bh)};
    pending_pairs.push_back(p);
  endfunction

  function automatic longint clip_center(longint v);
    if (v > MAX_CENTER) return MAX_CENTER;
    if (v < MIN_CENTER) return MIN_CENTER;
    return v;
  endfunction

  function automatic longint random_size();
    return longint'($urandom & 32'h3FFF_FFFF) >>> $urandom_range(29, 0);
  endfunction

  // Offset that mostly lands the other box across the own box edge.
  function automatic longint random_offset(longint ws, longint wo);
    longint     lim;
    logic [63:0] r;
    lim = ws / 2 + wo / 2 + 2;
    r   = {$urandom, $urandom};
    return longint'(r % 64'(2 * lim + 1)) - lim;
  endfunction

  // Random pair: mostly near pairs at random scale, some on a small grid, some raw bits.
  function automatic void queue_random_pair();
    longint ocx, ocy, ow, oh, bw, bh;
    int     roll;
    roll = $urandom_range(99, 0);
    if (roll < 65) begin
      ocx = longint'($signed(CENTER_W'($urandom)));
      ocy = longint'($signed(CENTER_W'($urandom)));
      ow  = random_size();
      oh  = random_size();
      bw  = random_size();
      bh  = random_size();
      queue_pair(ocx, ocy, ow, oh, clip_center(ocx + random_offset(ow, bw)),
                 clip_center(ocy + random_offset(oh, bh)), bw, bh);
    end else if (roll < 85) begin
      queue_pair($urandom_range(12, 0) - 6, $urandom_range(12, 0) - 6,
                 $urandom_range(12, 0), $urandom_range(12, 0),
                 $urandom_range(12, 0) - 6, $urandom_range(12, 0) - 6,
                 $urandom_range(12, 0), $urandom_range(12, 0));
    end else begin
      queue_pair($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
    end
  endfunction

  // Idle rates per phase: sender idles lightly first, then heavily, then not at all.
  function automatic int sender_idle_pct();
    if (accepted_pairs < PHASE1_AT) return 17;
    if (accepted_pairs < PHASE2_AT) return 82;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (accepted_pairs < PHASE1_AT) return 82;
    if (accepted_pairs < PHASE2_AT) return 17;
    return 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      err_cnt++;
    end
  endfunction

  // Input driver: records each accepted transfer and presents the next pair.
  always @(posedge clk) begin : input_driver
    box_pair_t driven;
    box_pair_t nxt;
    bit        hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_contacts.push_back(predict_contact(driven));
        accepted_pairs++;
      end
      // Hold off once until every outstanding result has come back.
      hold = 1'b0;
      if (accepted_pairs == DRAIN_AT && !drain_done) begin
        if (expected_contacts.size() == 0) drain_done = 1'b1;
        else hold = 1'b1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() > 0 && !hold &&
            $urandom_range(99, 0) >= sender_idle_pct()) begin
          nxt = pending_pairs.pop_front();
          driven = nxt;
          own_center_x   <= nxt.own.cx;
          own_center_y   <= nxt.own.cy;
          own_width      <= nxt.own.w;
          own_height     <= nxt.own.h;
          other_center_x <= nxt.other.cx;
          other_center_y <= nxt.other.cy;
          other_width    <= nxt.other.w;
          other_height   <= nxt.other.h;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    contact_t exp;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_contacts.size() == 0) begin
          $error("result transfer with no pair outstanding");
          err_cnt++;
        end else begin
          exp = expected_contacts.pop_front();
          check_field("hit", exp.hit, hit);
          check_field("contact_x", exp.cx, contact_x);
          check_field("contact_y", exp.cy, contact_y);
          check_field("normal_x", exp.nx, normal_x);
          check_field("normal_y", exp.ny, normal_y);
          check_field("penetration", exp.depth, penetration);
        end
      end
      out_stall <= ($urandom_range(99, 0) < receiver_stall_pct());
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** aabb_pair_collision_contact: FAILED **");
      $finish;
    end
  end

  // Stimulus, reset and end of test.
  initial begin
    // No overlap: zero boxes, edges touching in x and in y.
    queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
    queue_pair(0, 0, 2 * ONE, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE);
    queue_pair(0, 0, 2 * ONE, 2 * ONE, 0, -2 * ONE, 2 * ONE, 2 * ONE);
    // One clear winner for each face.
    queue_pair(0, 0, 2 * ONE, 2 * ONE, 2 * ONE - 1, 0, 2 * ONE, 2 * ONE);
    queue_pair(0, 0, 2 * ONE, 2 * ONE, -2 * ONE + 1, 0, 2 * ONE, 2 * ONE);
    queue_pair(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE - 1, 2 * ONE, 2 * ONE);
    queue_pair(0, 0, 2 * ONE, 2 * ONE, 0, -2 * ONE + 1, 2 * ONE, 2 * ONE);
    // Ties: all four equal, -x against +y, +y against -y.
    queue_pair(ONE, -ONE, 4 * ONE, 4 * ONE, ONE, -ONE, 4 * ONE, 4 * ONE);
    queue_pair(0, 0, 4, 4, -1, 1, 4, 4);
    queue_pair(0, 0, 8, 2, 0, 0, 8, 2);
    // Odd sizes, a size of one, and degenerate boxes.
    queue_pair(0, 0, 3, 3, 1, 1, 3, 3);
    queue_pair(0, 0, 1, 1, 0, 0, 4, 4);
    queue_pair(0, 0, 4, 4, 1, 1, 0, 0);
    queue_pair(MAX_CENTER, MIN_CENTER, MAX_SIZE, 0, MAX_CENTER, MIN_CENTER, 0, MAX_SIZE);
    // Range extremes, including contact clamped to either side.
    queue_pair(MAX_CENTER, MAX_CENTER, MAX_SIZE, MAX_SIZE,
               MAX_CENTER, MAX_CENTER, MAX_SIZE, MAX_SIZE);
    queue_pair(MIN_CENTER, MIN_CENTER, MAX_SIZE, MAX_SIZE,
               MIN_CENTER, MIN_CENTER, MAX_SIZE, MAX_SIZE);
    queue_pair(MIN_CENTER, MIN_CENTER, MAX_SIZE, MAX_SIZE,
               MAX_CENTER, MAX_CENTER, MAX_SIZE, MAX_SIZE);
    queue_pair(MIN_CENTER, MIN_CENTER, MAX_SIZE, MAX_SIZE,
               -(64'sd1 <<< 29), -(64'sd1 <<< 29), MAX_SIZE, MAX_SIZE);
    queue_pair(MAX_CENTER, MAX_CENTER, MAX_SIZE, MAX_SIZE,
               MAX_CENTER - (64'sd1 <<< 29), MAX_CENTER - (64'sd1 <<< 29),
               MAX_SIZE, MAX_SIZE);
    queue_pair(0, 0, MAX_SIZE, MAX_SIZE, 1000, -1000, 2, 2);
    queue_pair(MAX_CENTER, MIN_CENTER, 1, MAX_SIZE, MIN_CENTER, MAX_CENTER, MAX_SIZE, 1);

    for (int i = 0; i < RANDOM_PAIRS; i++) queue_random_pair();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait until every pair is taken and every result has come back.
    while (!(pending_pairs.size() == 0 && !in_valid && expected_contacts.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_contacts.size() != 0) begin
      $error("%0d results never arrived", expected_contacts.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("** aabb_pair_collision_contact: PASSED **");
    end else begin
      $display("** aabb_pair_collision_contact: FAILED **");
    end
    $finish;
  end

endmodule
